[design/pcxr_pkg.sv]
// pcxr_pkg: shared types, codes and helpers of the pcx run-length pixel decoder
// depends on nothing; imported by pcxr_seq and pcx_rle_pixel_decoder_core
`timescale 1ns / 1ps

package pcxr_pkg;

  // raw register widths
  localparam int unsigned PPL_W    = 12;
  localparam int unsigned LBYTES_W = 12;
  localparam int unsigned PLANES_W = 2;
  localparam int unsigned LTOTAL_W = 13;
  localparam int unsigned CFG_DW   = 13;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_PIXELS_PER_LINE = 2'd0;
  localparam logic [1:0] CFG_LINE_BYTES      = 2'd1;
  localparam logic [1:0] CFG_PLANE_COUNT     = 2'd2;
  localparam logic [1:0] CFG_LINE_TOTAL      = 2'd3;

  // plane count codes
  localparam logic [PLANES_W-1:0] PLANES_PAL = 2'd1;
  localparam logic [PLANES_W-1:0] PLANES_RGB = 2'd3;

  // input word modes
  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_STREAM  = 1'b1;

  // run marker decode
  localparam logic [7:0] RUN_MARK  = 8'hc0;
  localparam logic [5:0] RUN_COUNT = 6'h3f;

  // color key limits
  localparam logic [7:0] KEY_HIGH = 8'd248;
  localparam logic [7:0] KEY_LOW  = 8'd8;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [1:0] {
    ST_PIXEL      = 2'd0,
    ST_EARLY_END  = 2'd1,
    ST_BAD_PLANES = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BYTE,
    S_READ,
    S_EMIT,
    S_FINISH
  } seq_state_e;

  typedef struct packed {
    logic [PPL_W-1:0]    pixels_per_line;
    logic [LBYTES_W-1:0] line_bytes;
    logic [PLANES_W-1:0] plane_count;
    logic [LTOTAL_W-1:0] line_total;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] stream_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic       stream_end;
  } item_t;

  typedef struct packed {
    logic [7:0] pix_blue;
    logic [7:0] pix_green;
    logic [7:0] pix_red;
    logic [7:0] pix_alpha;
    logic       row_done;
    logic       image_done;
    status_e    status;
    logic       run_last;
  } res_t;

  function automatic logic is_key(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    logic magenta;
    logic teal;
    magenta = (r >= KEY_HIGH) && (g <= KEY_LOW) && (b >= KEY_HIGH);
    teal    = (r <= KEY_LOW) && (g >= KEY_HIGH) && (b >= KEY_HIGH);
    return magenta || teal;
  endfunction

endpackage

[design/pcxr_ram.sv]
// pcxr_ram: simple dual-port memory, one write and one registered read port
// no dependencies; used for the palette table and the plane line store
`timescale 1ns / 1ps

module pcxr_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pcxr_seq.sv]
// pcxr_seq: decode sequencer, one decoded byte per pass through the shared position unit
// depends on pcxr_pkg and pcxr_ram (palette table and plane line store)
`timescale 1ns / 1ps

module pcxr_seq
  import pcxr_pkg::*;
#(
  parameter int unsigned MAX_LINE_BYTES = 2048,
  parameter int unsigned MAX_LINES      = 4096
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  input  item_t item_i,
  output logic  idle_o,
  output logic  res_valid_o,
  output res_t  res_o,
  input  logic  res_ready_i
);

  localparam int unsigned LB_W  = $clog2(MAX_LINE_BYTES + 1);
  localparam int unsigned LBX_W = (LB_W > LBYTES_W) ? LB_W : LBYTES_W;
  localparam int unsigned LN_W  = $clog2(MAX_LINES + 1);
  localparam int unsigned LNX_W = (LN_W > LTOTAL_W) ? LN_W : LTOTAL_W;
  localparam int unsigned PS_W  = $clog2(3 * MAX_LINE_BYTES + 1);
  localparam int unsigned AW    = $clog2(2 * MAX_LINE_BYTES);

  // effective geometry, registered from the raw registers
  logic [LB_W-1:0] lb_c, w_c, lb_q, w_q;
  logic [LN_W-1:0] lines_c, lines_q;
  logic [PS_W-1:0] size_q, two_lb_q;
  logic            rgb_q;

  always_comb begin
    if (cfg_i.line_bytes == '0) begin
      lb_c = LB_W'(1);
    end else if (LBX_W'(cfg_i.line_bytes) > LBX_W'(MAX_LINE_BYTES)) begin
      lb_c = LB_W'(MAX_LINE_BYTES);
    end else begin
      lb_c = LB_W'(cfg_i.line_bytes);
    end
    if (cfg_i.pixels_per_line == '0) begin
      w_c = LB_W'(1);
    end else if (LBX_W'(cfg_i.pixels_per_line) > LBX_W'(lb_c)) begin
      w_c = lb_c;
    end else begin
      w_c = LB_W'(cfg_i.pixels_per_line);
    end
    if (cfg_i.line_total == '0) begin
      lines_c = LN_W'(1);
    end else if (LNX_W'(cfg_i.line_total) > LNX_W'(MAX_LINES)) begin
      lines_c = LN_W'(MAX_LINES);
    end else begin
      lines_c = LN_W'(cfg_i.line_total);
    end
  end

  always_ff @(posedge clk_i) begin
    lb_q     <= lb_c;
    w_q      <= w_c;
    lines_q  <= lines_c;
    two_lb_q <= PS_W'(lb_c) << 1;
    rgb_q    <= (cfg_i.plane_count == PLANES_RGB);
    size_q   <= (cfg_i.plane_count == PLANES_RGB) ?
                (PS_W'(lb_c) << 1) + PS_W'(lb_c) : PS_W'(lb_c);
  end

  // decode state and item registers
  seq_state_e      state_q, state_d;
  logic            run_pend_q, run_pend_d;
  logic [5:0]      run_len_q, run_len_d;
  logic [PS_W-1:0] pos_q, pos_d;
  logic [LN_W-1:0] line_q, line_d;
  logic            done_q, done_d;
  logic [7:0]      byte_q, byte_d;
  logic            end_q, end_d;
  logic [5:0]      cnt_q, cnt_d;
  status_e         status_q, status_d;
  logic            more_q, more_d;
  logic [AW-1:0]   x_q, x_d;
  logic            row_q, row_d;
  logic            img_q, img_d;
  logic [7:0]      red_q, red_d;
  logic            hold_valid_q, hold_valid_d;
  res_t            hold_q, hold_d;

  // memory ports
  logic          pal_we, pal_re;
  logic [23:0]   pal_rdata;
  logic          pl_we, pl_re;
  logic [AW-1:0] pl_waddr, pl_raddr;
  logic [7:0]    pl_rdata;

  pcxr_ram #(.DW(24), .DEPTH(256)) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (item_i.entry_index),
    .wdata_i ({item_i.entry_red, item_i.entry_green, item_i.entry_blue}),
    .re_i    (pal_re),
    .raddr_i (byte_q),
    .rdata_o (pal_rdata)
  );

  pcxr_ram #(.DW(8), .DEPTH(2 * MAX_LINE_BYTES)) u_planes (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_waddr),
    .wdata_i (byte_q),
    .re_i    (pl_re),
    .raddr_i (pl_raddr),
    .rdata_o (pl_rdata)
  );

  // shared position unit: one decoded byte against the scanline geometry
  logic            pos_in, line_end, last_line;
  logic [PS_W-1:0] pos_nx, x_rgb, x_sel;
  logic [LN_W:0]   line_inc;
  logic            pal_pix, rgb_wr, rgb_pix, is_pix, row_end;
  logic            accept, plane_ok, marker;
  logic [PS_W:0]   reach_sum;
  logic            reach, complete;
  logic [7:0]      pr, pg, pb;
  res_t            pix;

  always_comb begin
    pos_in    = pos_q < size_q;
    pos_nx    = pos_in ? pos_q + PS_W'(1) : pos_q;
    line_end  = pos_nx >= size_q;
    line_inc  = {1'b0, line_q} + (LN_W + 1)'(1);
    last_line = line_inc >= {1'b0, lines_q};
    x_rgb     = pos_q - two_lb_q;
    pal_pix   = pos_in && !rgb_q && (pos_q < PS_W'(w_q));
    rgb_wr    = pos_in && rgb_q && (pos_q < two_lb_q);
    rgb_pix   = pos_in && rgb_q && !(pos_q < two_lb_q) && (x_rgb < PS_W'(w_q));
    is_pix    = (pal_pix || rgb_pix) && (status_q == ST_PIXEL);
    x_sel     = rgb_q ? x_rgb : pos_q;
    row_end   = (x_sel + PS_W'(1)) == PS_W'(w_q);
    // whether the end word finishes the image
    reach_sum = {1'b0, pos_q} + (PS_W + 1)'(cnt_q);
    reach     = !pos_in || (reach_sum >= {1'b0, size_q});
    complete  = done_q || ((cnt_q != '0) && reach && last_line);
    accept    = in_valid_i && (state_q == S_IDLE);
    plane_ok  = (cfg_i.plane_count == PLANES_PAL) || (cfg_i.plane_count == PLANES_RGB);
    marker    = (item_i.stream_byte & RUN_MARK) == RUN_MARK;
    if (rgb_q) begin
      pr = red_q;
      pg = pl_rdata;
      pb = byte_q;
    end else begin
      pr = pal_rdata[23:16];
      pg = pal_rdata[15:8];
      pb = pal_rdata[7:0];
    end
    pix            = '0;
    pix.pix_red    = pr;
    pix.pix_green  = pg;
    pix.pix_blue   = pb;
    pix.pix_alpha  = is_key(pr, pg, pb) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    pix.row_done   = row_q;
    pix.image_done = img_q;
    pix.status     = ST_PIXEL;
  end

  always_comb begin
    state_d      = state_q;
    run_pend_d   = run_pend_q;
    run_len_d    = run_len_q;
    pos_d        = pos_q;
    line_d       = line_q;
    done_d       = done_q;
    byte_d       = byte_q;
    end_d        = end_q;
    cnt_d        = cnt_q;
    status_d     = status_q;
    more_d       = more_q;
    x_d          = x_q;
    row_d        = row_q;
    img_d        = img_q;
    red_d        = red_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    pal_we       = 1'b0;
    pal_re       = 1'b0;
    pl_we        = 1'b0;
    pl_re        = 1'b0;
    pl_waddr     = pos_q[AW-1:0];
    pl_raddr     = x_rgb[AW-1:0];
    res_valid_o  = 1'b0;
    res_o        = hold_q;
    res_o.run_last = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          byte_d   = item_i.stream_byte;
          end_d    = item_i.stream_end;
          status_d = ST_PIXEL;
          cnt_d    = '0;
          if (item_i.mode == MODE_PALETTE) begin
            pal_we = 1'b1;
          end else if (!plane_ok) begin
            status_d = ST_BAD_PLANES;
            state_d  = S_FINISH;
          end else begin
            if (done_q) begin
              cnt_d = '0;
            end else if (run_pend_q) begin
              cnt_d      = run_len_q;
              run_pend_d = 1'b0;
              run_len_d  = '0;
            end else if (marker) begin
              run_pend_d = 1'b1;
              run_len_d  = item_i.stream_byte[5:0] & RUN_COUNT;
            end else begin
              cnt_d = 6'd1;
            end
            if (item_i.stream_end) begin
              state_d = S_CHECK;
            end else if (cnt_d == '0) begin
              state_d = S_FINISH;
            end else begin
              state_d = S_BYTE;
            end
          end
        end
      end

      S_CHECK: begin
        // an end word that leaves the image short drops its pixels
        status_d = complete ? ST_PIXEL : ST_EARLY_END;
        state_d  = (cnt_q == '0) ? S_FINISH : S_BYTE;
      end

      S_BYTE: begin
        pl_we   = rgb_wr;
        pal_re  = is_pix && !rgb_q;
        pl_re   = is_pix && rgb_q;
        x_d     = x_sel[AW-1:0];
        row_d   = row_end;
        img_d   = row_end && last_line;
        cnt_d   = cnt_q - 6'd1;
        more_d  = !line_end && (cnt_q != 6'd1);
        pos_d   = pos_nx;
        if (line_end) begin
          pos_d  = '0;
          line_d = line_inc[LN_W-1:0];
          if (last_line) begin
            done_d = 1'b1;
          end
        end
        if (is_pix) begin
          state_d = rgb_q ? S_READ : S_EMIT;
        end else if (!line_end && (cnt_q != 6'd1)) begin
          state_d = S_BYTE;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_READ: begin
        red_d    = pl_rdata;
        pl_re    = 1'b1;
        pl_raddr = AW'(lb_q) + x_q;
        state_d  = S_EMIT;
      end

      S_EMIT: begin
        // the held pixel leaves only once a later one proves it is not the last
        res_valid_o = hold_valid_q;
        if (!hold_valid_q || res_ready_i) begin
          hold_d       = pix;
          hold_valid_d = 1'b1;
          state_d      = more_q ? S_BYTE : S_FINISH;
        end
      end

      S_FINISH: begin
        if (status_q != ST_PIXEL) begin
          res_valid_o = 1'b1;
          res_o       = '0;
          res_o.status = status_q;
        end else begin
          res_valid_o = hold_valid_q;
        end
        res_o.run_last = 1'b1;
        if (!res_valid_o || res_ready_i) begin
          hold_valid_d = 1'b0;
          state_d      = S_IDLE;
          if (end_q) begin
            run_pend_d = 1'b0;
            run_len_d  = '0;
            pos_d      = '0;
            line_d     = '0;
            done_d     = 1'b0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_pend_q   <= 1'b0;
      run_len_q    <= '0;
      pos_q        <= '0;
      line_q       <= '0;
      done_q       <= 1'b0;
      end_q        <= 1'b0;
      cnt_q        <= '0;
      status_q     <= ST_PIXEL;
      more_q       <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      run_pend_q   <= run_pend_d;
      run_len_q    <= run_len_d;
      pos_q        <= pos_d;
      line_q       <= line_d;
      done_q       <= done_d;
      end_q        <= end_d;
      cnt_q        <= cnt_d;
      status_q     <= status_d;
      more_q       <= more_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    x_q    <= x_d;
    row_q  <= row_d;
    img_q  <= img_d;
    red_q  <= red_d;
    hold_q <= hold_d;
  end

endmodule

[design/pcx_rle_pixel_decoder_core.sv]
// pcx_rle_pixel_decoder_core: top level of the pcx 8-bit run-length pixel decoder
// depends on pcxr_pkg and pcxr_seq; holds the register file and the output register
`timescale 1ns / 1ps

// usage
// - input channel (in_valid_i / in_stall_o): a word with mode 0 writes one palette
//   entry; mode 1 carries one compressed byte, stream_end_i on the last
// - output channel (out_valid_o / out_stall_i): one pixel or status word per result,
//   run_last_o marks the last word that an input word causes
// - config channel (cfg_valid_i / cfg_ready_o): always ready, index picks the register;
//   write only while the decoder is idle
// - timing: each decoded byte takes one pass of the sequencer through the position
//   unit: S_BYTE alone for a padding or plane byte, S_BYTE and S_EMIT for a palette
//   pixel, S_BYTE, S_READ and S_EMIT for a planar pixel (two reads of the line store
//   through its one read port); a word also passes S_IDLE, S_CHECK when stream_end_i
//   is set, and S_FINISH
// - one word is decoded at a time; in_stall_o stays high until its last result has
//   gone into the output register
// - a stalled receiver holds the output register and the sequencer waits on it
// - reset clears the decode position, pending run and registers (all to 1);
//   palette and line store contents are undefined until written
module pcx_rle_pixel_decoder_core
  import pcxr_pkg::*;
#(
  parameter int unsigned MAX_LINE_BYTES = 2048,
  parameter int unsigned MAX_LINES      = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  // input words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [7:0]        stream_byte_i,
  input  logic [7:0]        entry_index_i,
  input  logic [7:0]        entry_red_i,
  input  logic [7:0]        entry_green_i,
  input  logic [7:0]        entry_blue_i,
  input  logic              stream_end_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        pix_blue_o,
  output logic [7:0]        pix_green_o,
  output logic [7:0]        pix_red_o,
  output logic [7:0]        pix_alpha_o,
  output logic              row_done_o,
  output logic              image_done_o,
  output logic [1:0]        status_o,
  output logic              run_last_o
);

  // register file
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PIXELS_PER_LINE: cfg_d.pixels_per_line = cfg_data_i[PPL_W-1:0];
        CFG_LINE_BYTES:      cfg_d.line_bytes      = cfg_data_i[LBYTES_W-1:0];
        CFG_PLANE_COUNT:     cfg_d.plane_count     = cfg_data_i[PLANES_W-1:0];
        CFG_LINE_TOTAL:      cfg_d.line_total      = cfg_data_i[LTOTAL_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixels_per_line <= PPL_W'(1);
      cfg_q.line_bytes      <= LBYTES_W'(1);
      cfg_q.plane_count     <= PLANES_PAL;
      cfg_q.line_total      <= LTOTAL_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input word
  item_t item;
  logic  seq_idle;

  assign item.mode        = mode_i;
  assign item.stream_byte = stream_byte_i;
  assign item.entry_index = entry_index_i;
  assign item.entry_red   = entry_red_i;
  assign item.entry_green = entry_green_i;
  assign item.entry_blue  = entry_blue_i;
  assign item.stream_end  = stream_end_i;

  assign in_stall_o = !seq_idle;

  // sequencer
  logic res_valid;
  logic res_ready;
  res_t res;

  pcxr_seq #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_LINES      (MAX_LINES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .item_i      (item),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register, refilled in the cycle it drains
  logic out_valid_q, out_valid_d;
  res_t out_q, out_d;

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pix_blue_o   = out_q.pix_blue;
  assign pix_green_o  = out_q.pix_green;
  assign pix_red_o    = out_q.pix_red;
  assign pix_alpha_o  = out_q.pix_alpha;
  assign row_done_o   = out_q.row_done;
  assign image_done_o = out_q.image_done;
  assign status_o     = out_q.status;
  assign run_last_o   = out_q.run_last;

  // sequencer never offers a result in the cycle it takes a new word
  a_no_result_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !res_valid)
    else $error("result offered while taking an input word");

  // after a non-final result the same word is still being decoded
  a_busy_after_partial : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready && !res.run_last) |=> in_stall_o)
    else $error("input taken before the last result of a word");

  // the image ends only on a scanline end
  a_image_on_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!image_done_o || row_done_o))
    else $error("image_done without row_done");

endmodule

[sim/pcx_rle_pixel_decoder_core_tb.sv]
// pcx_rle_pixel_decoder_core_tb: self-checking bench for the pcx run-length pixel decoder
// depends on pcxr_pkg and pcx_rle_pixel_decoder_core; a built-in predictor checks
// every pixel and status word against directed and random streams
`timescale 1ns / 1ps

module pcx_rle_pixel_decoder_core_tb;
  import pcxr_pkg::*;

  localparam int unsigned LINE_BYTES_MAX = 2048;
  localparam int unsigned LINES_MAX      = 4096;
  localparam int unsigned RUN_LIMIT      = 63;
  // long enough for the decode of a 63-byte run, so this covers words with no result
  localparam int unsigned DRAIN_CYCLES   = 256;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              mode_i;
  logic [7:0]        stream_byte_i;
  logic [7:0]        entry_index_i;
  logic [7:0]        entry_red_i;
  logic [7:0]        entry_green_i;
  logic [7:0]        entry_blue_i;
  logic              stream_end_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [7:0]        pix_blue_o;
  logic [7:0]        pix_green_o;
  logic [7:0]        pix_red_o;
  logic [7:0]        pix_alpha_o;
  logic              row_done_o;
  logic              image_done_o;
  logic [1:0]        status_o;
  logic              run_last_o;

  pcx_rle_pixel_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .stream_byte_i (stream_byte_i),
    .entry_index_i (entry_index_i),
    .entry_red_i   (entry_red_i),
    .entry_green_i (entry_green_i),
    .entry_blue_i  (entry_blue_i),
    .stream_end_i  (stream_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pix_blue_o    (pix_blue_o),
    .pix_green_o   (pix_green_o),
    .pix_red_o     (pix_red_o),
    .pix_alpha_o   (pix_alpha_o),
    .row_done_o    (row_done_o),
    .image_done_o  (image_done_o),
    .status_o      (status_o),
    .run_last_o    (run_last_o)
  );

  // ---------------------------------------------------------------------------
  // predictor state: registers, palette, plane store and decode position
  // ---------------------------------------------------------------------------
  int unsigned ppl_r;
  int unsigned lbytes_r;
  int unsigned lines_r;
  logic [1:0]  planes_r;
  logic [23:0] pal_mem [256];
  logic [7:0]  plane_mem [2*LINE_BYTES_MAX];
  bit          run_armed;
  int unsigned run_cnt;
  int unsigned line_pos;
  int unsigned line_num;
  bit          img_full;

  res_t decoded_q [$];  // result words still owed by the decoder, oldest first
  res_t word_px [$];    // pixels of the stream byte being decoded

  // stimulus shaping, shared with the receiver process
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_left;

  // bookkeeping
  int unsigned err_count;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned keyed_seen;
  int unsigned early_seen;
  int unsigned bad_planes_seen;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned bytes_eff();
    if (lbytes_r < 1) return 1;
    if (lbytes_r > LINE_BYTES_MAX) return LINE_BYTES_MAX;
    return lbytes_r;
  endfunction

  function automatic int unsigned width_eff();
    int unsigned w;
    int unsigned b;
    w = ppl_r;
    b = bytes_eff();
    if (w < 1) w = 1;
    if (w > b) w = b;
    return w;
  endfunction

  function automatic int unsigned lines_eff();
    if (lines_r < 1) return 1;
    if (lines_r > LINES_MAX) return LINES_MAX;
    return lines_r;
  endfunction

  function automatic void restart_image();
    run_armed = 1'b0;
    run_cnt   = 0;
    line_pos  = 0;
    line_num  = 0;
    img_full  = 1'b0;
  endfunction

  function automatic void push_status(input status_e s);
    res_t p;
    p          = '0;
    p.status   = s;
    p.run_last = 1'b1;
    decoded_q.push_back(p);
  endfunction

  // one visible pixel at column x of the current scanline
  function automatic void push_pixel(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input int unsigned x);
    res_t p;
    bit   row_end;
    bit   keyed;
    row_end = (x + 1 == width_eff());
    if (word_px.size() >= RUN_LIMIT) return;
    // magenta-like or teal-like colors are transparent
    keyed = (r >= KEY_HIGH && g <= KEY_LOW && b >= KEY_HIGH) ||
            (r <= KEY_LOW && g >= KEY_HIGH && b >= KEY_HIGH);
    p            = '0;
    p.pix_blue   = b;
    p.pix_green  = g;
    p.pix_red    = r;
    p.pix_alpha  = keyed ? ALPHA_CLEAR : ALPHA_OPAQUE;
    p.row_done   = row_end;
    p.image_done = row_end && (line_num + 1 >= lines_eff());
    p.status     = ST_PIXEL;
    word_px.push_back(p);
  endfunction

  // place one decoded byte in the scanline; returns 1 when the scanline closes
  function automatic bit place_byte(input logic [7:0] v);
    int unsigned lb;
    int unsigned size;
    int unsigned pos;
    int unsigned wd;
    int unsigned x;
    logic [23:0] e;
    lb   = bytes_eff();
    size = (planes_r == PLANES_RGB) ? 3 * lb : lb;
    pos  = line_pos;
    wd   = width_eff();
    if (pos < size) begin
      if (planes_r == PLANES_RGB) begin
        if (pos < 2 * lb) begin
          plane_mem[pos & (2*LINE_BYTES_MAX - 1)] = v;
        end else begin
          x = pos - 2 * lb;
          if (x < wd) push_pixel(plane_mem[x], plane_mem[lb + x], v, x);
        end
      end else if (pos < wd) begin
        e = pal_mem[v];
        push_pixel(e[23:16], e[15:8], e[7:0], pos);
      end
      pos++;
    end
    line_pos = pos;
    // a byte at or past the scanline size closes the line without being stored
    if (pos >= size) begin
      line_pos = 0;
      line_num++;
      if (line_num >= lines_eff()) img_full = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // works out the result words of one accepted input word
  function automatic void decode_word(input item_t w);
    logic [7:0]  sb;
    int unsigned k;
    bit          cut;
    bit          done;
    res_t        p;
    sb = w.stream_byte;
    if (w.mode == MODE_PALETTE) begin
      pal_mem[w.entry_index] = {w.entry_red, w.entry_green, w.entry_blue};
      return;
    end
    // unsupported plane count: one status word per byte, nothing advances
    if (planes_r != PLANES_PAL && planes_r != PLANES_RGB) begin
      if (w.stream_end) restart_image();
      push_status(ST_BAD_PLANES);
      return;
    end
    word_px.delete();
    if (!img_full) begin
      if (run_armed) begin
        // value byte of a run, cut off at the scanline end
        run_armed = 1'b0;
        cut = 1'b0;
        for (k = 0; k < run_cnt && !img_full && !cut; k++) cut = place_byte(sb);
        run_cnt = 0;
      end else if ((sb & RUN_MARK) == RUN_MARK) begin
        run_armed = 1'b1;
        run_cnt   = sb & RUN_COUNT;
      end else begin
        void'(place_byte(sb));
      end
    end
    if (w.stream_end) begin
      done = img_full;
      restart_image();
      // early end drops the pixels of this byte
      if (!done) begin
        push_status(ST_EARLY_END);
        return;
      end
    end
    if (word_px.size() != 0) begin
      p = word_px.pop_back();
      p.run_last = 1'b1;
      word_px.push_back(p);
    end
    while (word_px.size() != 0) decoded_q.push_back(word_px.pop_front());
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset values, receiver and watchdog
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall per cycle, or a counted hold-off when requested
  initial begin : receiver
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else begin
        out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout: decoder stopped making progress");
    $display("pcx_rle_pixel_decoder_core_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 40) $display("error at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) flag_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("unexpected word status %0d", status_o));
      end else begin
        want = decoded_q.pop_front();
        check_field("pix_blue", pix_blue_o, want.pix_blue);
        check_field("pix_green", pix_green_o, want.pix_green);
        check_field("pix_red", pix_red_o, want.pix_red);
        check_field("pix_alpha", pix_alpha_o, want.pix_alpha);
        check_field("row_done", row_done_o, want.row_done);
        check_field("image_done", image_done_o, want.image_done);
        check_field("status", status_o, want.status);
        check_field("run_last", run_last_o, want.run_last);
        if (want.status == ST_PIXEL && want.pix_alpha == ALPHA_CLEAR) keyed_seen++;
        if (want.status == ST_EARLY_END) early_seen++;
        if (want.status == ST_BAD_PLANES) bad_planes_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // offers one word, with an optional random gap, and waits for acceptance
  task automatic send_word(input item_t w);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= w.mode;
    stream_byte_i <= w.stream_byte;
    entry_index_i <= w.entry_index;
    entry_red_i   <= w.entry_red;
    entry_green_i <= w.entry_green;
    entry_blue_i  <= w.entry_blue;
    stream_end_i  <= w.stream_end;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_word(w);
    words_sent++;
  endtask

  // stream byte; the palette fields carry noise that must be ignored
  task automatic send_byte(input logic [7:0] b, input logic last);
    item_t w;
    w.mode        = MODE_STREAM;
    w.stream_byte = b;
    w.entry_index = $urandom;
    w.entry_red   = $urandom;
    w.entry_green = $urandom;
    w.entry_blue  = $urandom;
    w.stream_end  = last;
    send_word(w);
  endtask

  // palette write; stream fields carry noise
  task automatic send_entry(input logic [7:0] idx, input logic [23:0] rgb);
    item_t w;
    w.mode        = MODE_PALETTE;
    w.stream_byte = $urandom;
    w.entry_index = idx;
    w.entry_red   = rgb[23:16];
    w.entry_green = rgb[15:8];
    w.entry_blue  = rgb[7:0];
    w.stream_end  = $urandom_range(1);
    send_word(w);
  endtask

  task automatic send_run(input logic [5:0] cnt, input logic [7:0] v);
    send_byte(RUN_MARK | {2'b00, cnt}, 1'b0);
    send_byte(v, 1'b0);
  endtask

  // mostly random colors, with a share close to the transparent keys
  function automatic logic [23:0] rand_colour();
    case ($urandom_range(7))
      0: return {8'($urandom_range(246, 255)), 8'($urandom_range(0, 10)),
                 8'($urandom_range(246, 255))};
      1: return {8'($urandom_range(0, 10)), 8'($urandom_range(246, 255)),
                 8'($urandom_range(246, 255))};
      default: return 24'($urandom);
    endcase
  endfunction

  // drains all owed words, then lets the sequencer settle before a register write
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_DW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PIXELS_PER_LINE: ppl_r    = val[PPL_W-1:0];
      CFG_LINE_BYTES:      lbytes_r = val[LBYTES_W-1:0];
      CFG_PLANE_COUNT:     planes_r = val[PLANES_W-1:0];
      CFG_LINE_TOTAL:      lines_r  = val[LTOTAL_W-1:0];
      default: ;
    endcase
  endtask

  // writes all four registers back to back
  task automatic configure(input int unsigned ppl, input int unsigned lb,
                           input logic [1:0] planes, input int unsigned lines);
    write_reg(CFG_PIXELS_PER_LINE, ppl);
    write_reg(CFG_LINE_BYTES, lb);
    write_reg(CFG_PLANE_COUNT, planes);
    write_reg(CFG_LINE_TOTAL, lines);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // whole palette, so no lookup ever hits an unwritten entry; low entries sit on
  // both sides of the key limits
  task automatic test_load_palette();
    int unsigned k;
    logic [23:0] rgb;
    for (k = 0; k < 256; k++) begin
      case (k)
        0:       rgb = 24'h000000;
        1:       rgb = {8'd248, 8'd8, 8'd248};
        2:       rgb = {8'd247, 8'd8, 8'd248};
        3:       rgb = {8'd8, 8'd248, 8'd248};
        4:       rgb = {8'd8, 8'd247, 8'd248};
        5:       rgb = 24'hff00ff;
        6:       rgb = {8'd0, 8'd255, 8'd247};
        255:     rgb = 24'hffffff;
        default: rgb = rand_colour();
      endcase
      send_entry(k, rgb);
    end
    wait_idle();
  endtask

  // reset registers give a 1 x 1 palette image
  task automatic test_reset_defaults();
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b1);  // image already complete, so nothing
    wait_idle();
  endtask

  // literals, runs across the row end, zero run, cut run, bytes after the image,
  // end after a complete image and an early end
  task automatic test_literals_and_runs();
    configure(4, 6, PLANES_PAL, 2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_run(6'd3, 8'hff);
    send_run(6'd0, 8'h55);
    send_run(6'd63, 8'h12);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h08, 1'b1);
    send_byte(8'h10, 1'b1);
    wait_idle();
  endtask

  // planar rgb with a keyed pixel and a padding byte carrying the end flag
  task automatic test_planar_key();
    configure(2, 3, PLANES_RGB, 1);
    send_run(6'd2, 8'hf8);
    send_byte(8'h00, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h00, 1'b0);
    send_run(6'd1, 8'hfa);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    wait_idle();
  endtask

  // plane counts 2 and 0 answer every stream byte with a status word
  task automatic test_bad_planes();
    configure(1, 1, 2'd2, 1);
    send_byte(8'h33, 1'b0);
    send_entry(8'h80, rand_colour());
    send_byte(8'hc5, 1'b1);
    wait_idle();
    configure(1, 1, 2'd0, 1);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hff, 1'b1);
    wait_idle();
  endtask

  // out of range registers and the widest scanline
  task automatic test_register_clamps();
    int unsigned k;
    configure(0, 0, PLANES_PAL, 0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    wait_idle();
    configure(10, 5, PLANES_PAL, 1);  // width limited to the line bytes
    send_run(6'd5, 8'h07);
    send_byte(8'h09, 1'b1);
    wait_idle();
    configure(4095, 4095, PLANES_PAL, 8191);
    for (k = 0; k < 32; k++) send_run(6'd63, $urandom);
    send_run(6'd32, $urandom);
    send_byte(8'h21, 1'b1);
    wait_idle();
  endtask

  // shrinking the scanline mid-image closes the current line
  task automatic test_midline_shrink();
    int unsigned k;
    configure(8, 8, PLANES_PAL, 2);
    for (k = 0; k < 5; k++) send_byte($urandom_range(0, 8'hbf), 1'b0);
    wait_idle();
    configure(8, 3, PLANES_PAL, 2);
    for (k = 0; k < 4; k++) send_byte($urandom_range(0, 8'hbf), 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while long runs keep coming
  task automatic test_backpressure();
    int unsigned k;
    configure(40, 40, PLANES_PAL, 30);
    hold_left <= 400;
    for (k = 0; k < 12; k++) send_run($urandom_range(40, 63), $urandom);
    send_byte($urandom, 1'b1);
    wait_idle();
  endtask

  // one image of random content; mostly well-formed, sometimes cut short
  task automatic random_image(inout int unsigned used);
    int unsigned cap;
    int unsigned n;
    int unsigned pick;
    n   = 0;
    cap = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : $urandom_range(20, 45);
    while (!img_full && n < cap) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_entry($urandom, rand_colour());
      end else if (pick < 12) begin
        send_run(6'd0, $urandom);
        n++;
      end else if (pick < 50) begin
        send_byte($urandom_range(0, 8'hbf), 1'b0);
      end else begin
        send_run($urandom_range(1, RUN_LIMIT), $urandom);
        n++;
      end
      n++;
    end
    // trailing bytes after a complete image are ignored
    if (img_full && $urandom_range(2) == 0) begin
      send_byte($urandom, 1'b0);
      n++;
    end
    send_byte($urandom, 1'b1);
    used += n + 1;
  endtask

  task automatic random_phase(input int unsigned gap, input int unsigned stall,
                              input int unsigned budget);
    int unsigned used;
    int unsigned lb;
    int unsigned ppl;
    int unsigned lines;
    logic [1:0]  planes;
    gap_pct   = gap;
    stall_pct = stall;
    used      = 0;
    while (used < budget) begin
      case ($urandom_range(19))
        0:                   planes = 2'd2;
        1:                   planes = 2'd0;
        2, 3, 4, 5, 6, 7, 8: planes = PLANES_PAL;
        default:             planes = PLANES_RGB;
      endcase
      lb    = $urandom_range(1, 24);
      ppl   = ($urandom_range(4) == 0) ? $urandom_range(0, lb + 4) : $urandom_range(1, lb);
      lines = ($urandom_range(4) == 0) ? $urandom_range(0, 5) : $urandom_range(1, 3);
      configure(ppl, lb, planes, lines);
      random_image(used);
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_PALETTE;
    stream_byte_i = '0;
    entry_index_i = '0;
    entry_red_i   = '0;
    entry_green_i = '0;
    entry_blue_i  = '0;
    stream_end_i  = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    err_count     = 0;
    words_sent    = 0;
    results_seen  = 0;
    keyed_seen    = 0;
    early_seen    = 0;
    bad_planes_seen = 0;
    // predictor follows the reset state of the decoder
    ppl_r    = 1;
    lbytes_r = 1;
    planes_r = PLANES_PAL;
    lines_r  = 1;
    for (k = 0; k < 256; k++) pal_mem[k] = '0;
    for (k = 0; k < 2*LINE_BYTES_MAX; k++) plane_mem[k] = '0;
    restart_image();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_load_palette();
    test_reset_defaults();
    test_literals_and_runs();
    test_planar_key();
    test_bad_planes();
    test_register_clamps();
    test_midline_shrink();
    test_backpressure();
    random_phase(0, 0, 65);
    random_phase(61, 0, 65);
    random_phase(0, 61, 65);
    random_phase(30, 30, 65);

    $display("covered %0d input words and %0d result words over palette, planar,",
             words_sent, results_seen);
    $display("clamped and unsupported setups: %0d keyed, %0d early ends, %0d bad planes",
             keyed_seen, early_seen, bad_planes_seen);
    if (err_count == 0) begin
      $display("pcx_rle_pixel_decoder_core_tb OK");
    end else begin
      $display("pcx_rle_pixel_decoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule
